// ----- rtl/bhr_pkg.sv -----
// bhr_pkg: shared constants for the binaural renderer
// response length, derived address and count widths, register and sequencer codes
// no dependencies
package bhr_pkg;

  localparam int RESPONSE_LENGTH = 64;
  localparam int ADDR_W  = $clog2(RESPONSE_LENGTH);
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int COUNT_W = $clog2(RESPONSE_LENGTH + 1);
  localparam int MAX_DELAY = RESPONSE_LENGTH - 8;
  localparam int REFLECT_OFFSET = 4;

  localparam logic [1:0] REG_SOURCE_X = 2'd0;
  localparam logic [1:0] REG_SOURCE_Y = 2'd1;
  localparam logic [1:0] REG_SOURCE_Z = 2'd2;
  localparam logic [1:0] REG_UNUSED   = 2'd3;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQ   = 4'd1;
  localparam logic [3:0] ST_SQRT = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_G1   = 4'd4;
  localparam logic [3:0] ST_G2   = 4'd5;
  localparam logic [3:0] ST_G3   = 4'd6;
  localparam logic [3:0] ST_G4   = 4'd7;
  localparam logic [3:0] ST_G5   = 4'd8;
  localparam logic [3:0] ST_TAP  = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;

endpackage

// ----- rtl/binaural_hrir_renderer.sv -----
// binaural_hrir_renderer: two-tap per-ear binaural filter over a sample history memory
// uses bhr_pkg; response sequencer for position updates and a history read sequencer
//
//   channel   signals                                       dir
//   config    cfg_we, cfg_index, cfg_data                   in
//   input     in_valid, in_ready, mono_sample, end_of_block in
//   output    out_valid, out_ready, left/right_sample, block_last out
//
// each sample passes through a history write, four history reads through the
// single read port with a multiply-accumulate behind each, and a rounding step
// a source register write rebuilds the response (squares, sqrt, divisions, gains);
// in_ready stays low meanwhile (sqrt and division run a bit pair / bit a cycle)
// rst clears control, loads the response of the origin position
// a result waiting on out_ready holds the next sample in the rounding step
module binaural_hrir_renderer
  import bhr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] mono_sample,
  input  logic               end_of_block,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] left_sample,
  output logic signed [15:0] right_sample,
  output logic               block_last
);

  logic [3:0] state;
  logic [4:0] step;
  logic [1:0] coord;

  logic signed [15:0] source_x, source_y, source_z;

  logic [31:0] sq;
  logic [47:0] sv, sres, sbit, strial;
  logic [24:0] distance;
  logic [25:0] rem, rem_sh;
  logic [17:0] quo;
  logic        neg;
  logic signed [15:0] csel;
  logic signed [31:0] csq;
  logic [16:0] cmag;
  logic signed [17:0] nx, ny, nz, nq;

  logic signed [33:0] px, pz, accl, accr, base;
  logic [16:0] al, ar;
  logic [29:0] ml, mr;
  logic [46:0] pl, pr;
  logic [16:0] nz_off;
  logic [5:0]  dl_raw, dr_raw;

  logic [ADDR_W-1:0] left_delay_taps, right_delay_taps;
  logic [16:0] left_direct_gain, right_direct_gain;
  logic signed [15:0] left_reflect_gain, right_reflect_gain;

  logic signed [15:0] hist_mem [MEM_DEPTH];
  logic signed [15:0] rd_data;
  logic [ADDR_W-1:0] wp, rd_addr;
  logic [COUNT_W-1:0] history_count, count_next;
  logic [ADDR_W:0] age [4];
  logic [3:0] tap_ok;
  logic       eob;
  logic signed [17:0] gsel;
  logic signed [15:0] tsel;
  logic signed [33:0] prod;
  logic signed [34:0] acc_l, acc_r;
  logic signed [19:0] rnd_l, rnd_r;
  logic signed [15:0] sat_l, sat_r;
  logic       fin_fire;

  function automatic logic [ADDR_W-1:0] clamp_delay(input logic [5:0] v);
    if (int'(v) > MAX_DELAY) return ADDR_W'(MAX_DELAY);
    return ADDR_W'(v);
  endfunction

  function automatic logic [16:0] gain_of(input logic signed [33:0] a);
    logic signed [33:0] c;
    logic signed [33:0] s;
    c = a;
    if (c < 34'sd107380736) c = 34'sd107380736;
    if (c > 34'sd1073741824) c = 34'sd1073741824;
    s = (c + 34'sd16384) >>> 15;
    return s[16:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sh7fff;
    if (v < -20'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  assign in_ready = (state == ST_IDLE);
  assign fin_fire = (state == ST_FIN) && !cfg_we && (!out_valid || out_ready);

  always_comb begin
    unique case (coord)
      2'd0:    csel = source_x;
      2'd1:    csel = source_y;
      default: csel = source_z;
    endcase
    csq    = csel * csel;
    cmag   = csel[15] ? 17'(-$signed({csel[15], csel})) : {1'b0, csel};
    strial = sres + sbit;
    rem_sh = {rem[24:0], 1'b0};
    nq     = neg ? -$signed(quo) : $signed(quo);
    nz_off = 17'($signed({nz[17], nz}) + 19'sd32768);
    dl_raw = 6'(17'(19'sd32768 - $signed({ny[17], ny})) >> 11);
    dr_raw = 6'(17'($signed({ny[17], ny}) + 19'sd32768) >> 11);
    base   = 34'sd536870912 + px + pz;
    accl   = base + (34'(ny) <<< 14);
    accr   = base - (34'(ny) <<< 14);
  end

  // tap ages, history read address, gain and tap select, rounding and saturation
  always_comb begin
    count_next = (int'(history_count) < RESPONSE_LENGTH) ? history_count + 1'b1
                                                         : history_count;
    age[0] = {1'b0, left_delay_taps};
    age[1] = {1'b0, left_delay_taps} + (ADDR_W+1)'(REFLECT_OFFSET);
    age[2] = {1'b0, right_delay_taps};
    age[3] = {1'b0, right_delay_taps} + (ADDR_W+1)'(REFLECT_OFFSET);
    rd_addr = wp - age[step[1:0]][ADDR_W-1:0];
    unique case (step[1:0])
      2'd1:    gsel = $signed({1'b0, left_direct_gain});
      2'd2:    gsel = 18'(left_reflect_gain);
      2'd3:    gsel = $signed({1'b0, right_direct_gain});
      default: gsel = 18'(right_reflect_gain);
    endcase
    tsel  = tap_ok[step[1:0] - 2'd1] ? rd_data : 16'sd0;
    prod  = tsel * gsel;
    rnd_l = 20'((acc_l + 35'sd16384) >>> 15);
    rnd_r = 20'((acc_r + 35'sd16384) >>> 15);
    sat_l = sat16(rnd_l);
    sat_r = sat16(rnd_r);
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) hist_mem[wp + 1'b1] <= mono_sample;
    rd_data <= hist_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      coord <= '0;
      source_x <= '0;
      source_y <= '0;
      source_z <= '0;
      left_delay_taps <= ADDR_W'(16);
      right_delay_taps <= ADDR_W'(16);
      left_direct_gain <= 17'd16384;
      right_direct_gain <= 17'd16384;
      left_reflect_gain <= -16'sd3277;
      right_reflect_gain <= -16'sd3277;
      wp <= '0;
      history_count <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SOURCE_X: source_x <= cfg_data;
          REG_SOURCE_Y: source_y <= cfg_data;
          REG_SOURCE_Z: source_z <= cfg_data;
          default: ;
        endcase
        if (cfg_index != REG_UNUSED) begin
          state <= ST_SQ;
          step <= '0;
          coord <= '0;
          sq <= '0;
        end
      end else begin
        unique case (state)
          ST_IDLE: begin
            if (in_valid) begin
              wp <= wp + 1'b1;
              history_count <= count_next;
              eob <= end_of_block;
              for (int k = 0; k < 4; k++)
                tap_ok[k] <= age[k] < (ADDR_W+1)'(count_next);
              acc_l <= '0;
              acc_r <= '0;
              step <= '0;
              state <= ST_TAP;
            end
          end
          ST_SQ: begin
            sq <= sq + 32'(csq);
            if (coord == 2'd2) begin
              coord <= '0;
              step <= '0;
              sres <= '0;
              sbit <= 48'd1 << 46;
              sv <= {sq + 32'(csq), 16'd0};
              state <= ST_SQRT;
            end else begin
              coord <= coord + 1'b1;
            end
          end
          ST_SQRT: begin
            if (sv >= strial) begin
              sv <= sv - strial;
              sres <= (sres >> 1) + sbit;
            end else begin
              sres <= sres >> 1;
            end
            sbit <= sbit >> 2;
            if (step == 5'd23) begin
              step <= '0;
              state <= ST_DIV;
            end else begin
              step <= step + 1'b1;
            end
            if (step == 5'd0) begin
              rem <= '0;
            end
          end
          ST_DIV: begin
            if (step == 5'd0) begin
              distance <= (sres[24:0] < 25'd256) ? 25'd256 : sres[24:0];
              rem <= {4'd0, cmag, 5'd0};
              neg <= csel[15];
              quo <= '0;
              step <= 5'd1;
            end else begin
              if (rem_sh >= {1'b0, distance}) begin
                rem <= rem_sh - {1'b0, distance};
                quo <= {quo[16:0], 1'b1};
              end else begin
                rem <= rem_sh;
                quo <= {quo[16:0], 1'b0};
              end
              if (step == 5'd19) begin
                unique case (coord)
                  2'd0:    nx <= nq;
                  2'd1:    ny <= nq;
                  default: nz <= nq;
                endcase
                step <= 5'd20;
              end else if (step == 5'd20) begin
                step <= '0;
                if (coord == 2'd2) begin
                  coord <= '0;
                  state <= ST_G1;
                end else begin
                  coord <= coord + 1'b1;
                end
              end else begin
                step <= step + 1'b1;
              end
            end
          end
          ST_G1: begin
            px <= 34'(nx * 18'sd3277);
            pz <= 34'(nz * 18'sd1638);
            left_delay_taps <= clamp_delay(dl_raw);
            right_delay_taps <= clamp_delay(dr_raw);
            state <= ST_G2;
          end
          ST_G2: begin
            al <= gain_of(accl);
            ar <= gain_of(accr);
            state <= ST_G3;
          end
          ST_G3: begin
            left_direct_gain <= al;
            right_direct_gain <= ar;
            ml <= 30'(al * 17'd6554);
            mr <= 30'(ar * 17'd6554);
            state <= ST_G4;
          end
          ST_G4: begin
            pl <= 47'(ml * nz_off);
            pr <= 47'(mr * nz_off);
            state <= ST_G5;
          end
          ST_G5: begin
            left_reflect_gain <= -$signed(16'((pl + 47'd536870912) >> 30));
            right_reflect_gain <= -$signed(16'((pr + 47'd536870912) >> 30));
            state <= ST_IDLE;
          end
          ST_TAP: begin
            if (step != 5'd0) begin
              if (step <= 5'd2) acc_l <= acc_l + 35'(prod);
              else acc_r <= acc_r + 35'(prod);
            end
            if (step == 5'd4) state <= ST_FIN;
            step <= step + 1'b1;
          end
          ST_FIN: begin
            if (fin_fire) begin
              left_sample <= sat_l;
              right_sample <= sat_r;
              block_last <= eob;
              if (eob) history_count <= '0;
              state <= ST_IDLE;
            end
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

endmodule

// ----- rtl/bhr_checker.sv -----
// bhr_port_checks: port-level checks for the binaural renderer
// bound to binaural_hrir_renderer; uses bhr_pkg for register codes
module bhr_port_checks
  import bhr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] left_sample,
  input logic [15:0] right_sample,
  input logic        block_last
);

  // stalled output beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_sample)
      && $stable(right_sample) && $stable(block_last))
    else $error("output beat changed under stall");

  // one sample in flight
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // position update blocks samples while the response is rebuilt
  assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index != REG_UNUSED) |=> !in_ready)
    else $error("input ready during response rebuild");

  // reset empties the output
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind binaural_hrir_renderer bhr_port_checks u_bhr_checker (
  .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .in_valid(in_valid),
  .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
  .left_sample(left_sample), .right_sample(right_sample), .block_last(block_last)
);

// ----- tb/sv/bhr_checker.sv -----
`timescale 1ns / 100ps
// bhr_checker: watches the config, input and output channels of the binaural renderer
// keeps its own copy of position, response and sample history, predicts each output beat
// and compares it field by field; depends on bhr_pkg only
module bhr_checker
  import bhr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] mono_sample,
  input  logic               end_of_block,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] left_sample,
  input  logic signed [15:0] right_sample,
  input  logic               block_last,
  output int                 err_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last;
  } stereo_beat_t;

  stereo_beat_t expected_beats[$];

  logic signed [15:0] pos_x, pos_y, pos_z;
  longint             hist[RESPONSE_LENGTH];
  int                 hist_fill;
  int                 dly_l, dly_r;
  longint             dir_l, dir_r, refl_l, refl_r;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic int limit_delay(input longint d);
    if (d < 0) d = 0;
    if (d > MAX_DELAY) d = MAX_DELAY;
    return int'(d);
  endfunction

  task automatic ear_gain(input longint acc, input longint nz, input int dly,
                          output longint direct, output longint refl);
    longint lo, hi, a;
    lo = 64'sd3277 * 32768;
    hi = 64'sd32768 * 32768;
    if (acc < lo) acc = lo;
    if (acc > hi) acc = hi;
    a = (acc + 16384) >>> 15;
    direct = a;
    if (dly + REFLECT_OFFSET < RESPONSE_LENGTH)
      refl = -((64'sd6554 * a * (32768 + nz) + (64'sd1 << 29)) >>> 30);
    else
      refl = 0;
  endtask

  task automatic rebuild_response();
    longint x, y, z, d, nx, ny, nz, base;
    longint unsigned sq;
    x = pos_x;
    y = pos_y;
    z = pos_z;
    sq = x * x + y * y + z * z;
    d = longint'(int_sqrt(sq << 16));
    if (d < 256) d = 256;
    nx = (x * 8388608) / d;
    ny = (y * 8388608) / d;
    nz = (z * 8388608) / d;
    dly_l = limit_delay((16 * 32768 - 16 * ny) / 32768);
    dly_r = limit_delay((16 * 32768 + 16 * ny) / 32768);
    base = 64'sd16384 * 32768 + 3277 * nx + 1638 * nz;
    ear_gain(base + 16384 * ny, nz, dly_l, dir_l, refl_l);
    ear_gain(base - 16384 * ny, nz, dly_r, dir_r, refl_r);
  endtask

  function automatic longint tap_at(input int d);
    if (d >= RESPONSE_LENGTH || d >= hist_fill) return 0;
    return hist[d];
  endfunction

  function automatic logic signed [15:0] round_sat(input longint acc);
    longint r;
    r = ((acc + (64'sd1 << 40) + 16384) >>> 15) - (64'sd1 << 25);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic clear_history();
    for (int i = 0; i < RESPONSE_LENGTH; i++) hist[i] = 0;
    hist_fill = 0;
  endtask

  task automatic predict_beat(input logic signed [15:0] s, input logic e);
    stereo_beat_t b;
    for (int i = RESPONSE_LENGTH - 1; i > 0; i--) hist[i] = hist[i - 1];
    hist[0] = s;
    if (hist_fill < RESPONSE_LENGTH) hist_fill++;
    b.left  = round_sat(tap_at(dly_l) * dir_l + tap_at(dly_l + REFLECT_OFFSET) * refl_l);
    b.right = round_sat(tap_at(dly_r) * dir_r + tap_at(dly_r + REFLECT_OFFSET) * refl_r);
    b.last  = e;
    expected_beats.push_back(b);
    if (e) clear_history();
  endtask

  initial begin
    err_count = 0;
    pending = 0;
    pos_x = 0;
    pos_y = 0;
    pos_z = 0;
    clear_history();
    rebuild_response();
  end

  always @(posedge clk) begin
    stereo_beat_t want;
    if (rst) begin
      pos_x = 0;
      pos_y = 0;
      pos_z = 0;
      clear_history();
      rebuild_response();
      expected_beats.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SOURCE_X: pos_x = cfg_data;
          REG_SOURCE_Y: pos_y = cfg_data;
          REG_SOURCE_Z: pos_z = cfg_data;
          default: ;
        endcase
        if (cfg_index != REG_UNUSED) rebuild_response();
      end
      if (in_valid && in_ready) predict_beat(mono_sample, end_of_block);
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected output beat left %0d right %0d last %0b",
                   $time, left_sample, right_sample, block_last);
          err_count++;
        end else begin
          want = expected_beats.pop_front();
          if (left_sample !== want.left) begin
            $display("%0t: left_sample expected %0d actual %0d", $time, want.left,
                     left_sample);
            err_count++;
          end
          if (right_sample !== want.right) begin
            $display("%0t: right_sample expected %0d actual %0d", $time, want.right,
                     right_sample);
            err_count++;
          end
          if (block_last !== want.last) begin
            $display("%0t: block_last expected %0b actual %0b", $time, want.last,
                     block_last);
            err_count++;
          end
        end
      end
    end
    pending = expected_beats.size();
  end

endmodule

// ----- tb/sv/tb_binaural_hrir_renderer.sv -----
`timescale 1ns / 100ps
// tb_binaural_hrir_renderer: stimulus and verdict for the binaural renderer
// drives positions and sample blocks with bursty input and stalling output;
// depends on bhr_pkg, binaural_hrir_renderer and bhr_checker
module tb_binaural_hrir_renderer
  import bhr_pkg::*;
();

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_we = 0;
  logic [1:0]         cfg_index = 0;
  logic [15:0]        cfg_data = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic signed [15:0] mono_sample = 0;
  logic               end_of_block = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               block_last;
  int                 err_count;
  int                 pending;
  int                 burst_left = 0;
  int                 stall_mode = 0;
  int                 stall_cnt = 0;

  always #1 clk = ~clk;

  binaural_hrir_renderer u_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .mono_sample, .end_of_block,
    .out_valid, .out_ready, .left_sample, .right_sample, .block_last
  );

  bhr_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .mono_sample, .end_of_block,
    .out_valid, .out_ready, .left_sample, .right_sample, .block_last,
    .err_count, .pending
  );

  // receiver stall pattern: modes change every so often
  always @(negedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_cnt = $urandom_range(20, 120);
    end
    stall_cnt--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (stall_cnt % 16) < 10;
    endcase
  end

  task automatic send_beat(input logic [15:0] s, input logic e);
    if (burst_left == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid = 1;
    mono_sample = s;
    end_of_block = e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic settle();
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_position(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z);
    settle();
    write_reg(REG_SOURCE_X, x);
    write_reg(REG_SOURCE_Y, y);
    write_reg(REG_SOURCE_Z, z);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int n, blen;
    repeat (3) @(negedge clk);
    rst = 0;

    // origin position, extremes of the sample, short block
    send_beat(16'h7fff, 1'b0);
    send_beat(16'h8000, 1'b0);
    send_beat(16'h0001, 1'b1);
    // hard left: long delay on the right ear, beyond the short block's history
    set_position(16'h0000, 16'h7fff, 16'h0000);
    for (int i = 0; i < 8; i++) send_beat(i[0] ? 16'h8000 : 16'h7fff, 1'b0);
    send_beat(16'h7fff, 1'b1);
    // hard right, down, back; unused register index ignored
    set_position(16'h8000, 16'h8000, 16'h8000);
    write_reg(REG_UNUSED, 16'hffff);
    for (int i = 0; i < 7; i++) send_beat(16'h7fff, i == 6);
    // source on the z axis with a tiny x offset, written between blocks
    set_position(16'h0001, 16'h0000, 16'h7fff);
    send_beat(16'h8000, 1'b0);
    send_beat(16'h7fff, 1'b1);

    n = 0;
    while (n < 1300) begin
      set_position(rand_coord(), rand_coord(), rand_coord());
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom));
      for (int b = 0; b < $urandom_range(1, 3); b++) begin
        blen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10)
                                           : $urandom_range(30, 90);
        for (int i = 0; i < blen; i++) begin
          send_beat(rand_sample(), (i == blen - 1) && ($urandom_range(0, 5) != 0));
          n++;
        end
      end
    end
    settle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
